### rtl/sle_pkg.sv
// Shared package of the sequential list engine: field widths, mode, status and
// sequencer state codes, and the default capacity.
// Depends on nothing; imported by rtl/sequential_list_engine.sv and test/testbench.sv.
package sle_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned LEN_W        = 7;

  typedef enum logic [2:0] {
    MODE_GET      = 3'd0,
    MODE_INSERT   = 3'd1,
    MODE_DELETE   = 3'd2,
    MODE_LOCATE   = 3'd3,
    MODE_PRED     = 3'd4,
    MODE_SUCC     = 3'd5,
    MODE_CLEAR    = 3'd6,
    MODE_READ_ALL = 3'd7
  } sle_mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_NONE    = 2'd2,
    ST_FULL    = 2'd3
  } sle_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_GET,
    S_INS_SHIFT,
    S_INS_KEY,
    S_DEL_WALK,
    S_SEARCH,
    S_READ_ALL,
    S_DONE
  } sle_state_e;

endpackage

### rtl/sequential_list_engine.sv
// Sequential list engine: ordered list of signed 32-bit elements in a
// single-port-write, single-port-read element memory, walked by a small sequencer.
// Depends on rtl/sle_pkg.sv.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command item: mode_i,
//   position_i, key_value_i. in_ready_o is high only while the sequencer is idle,
//   so one item is in work at a time. Output channel (out_valid_o/out_ready_i)
//   carries result items from an output register; the next command is taken
//   while the last result still waits there.
//   Every command gives one result, except read-all of a non-empty list, which
//   gives one result per element with last_o on the final one.
//   The single memory read port gives one element per cycle, so insert, delete,
//   locate/predecessor/successor and read-all walk the list one element at a
//   time, read-all only while the receiver is ready. The squared locate rule
//   adds a squaring step before the search.
//   match_rule is written through cfg_we_i/cfg_wdata_i while idle.
//   Reset empties the list (count zero) and clears match_rule; the element
//   memory itself is not cleared, so no clearing pass runs.
//   When the receiver stalls, the output register holds its item and the
//   sequencer waits in its final step (read-all pauses between elements).
module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               mode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] key_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [LEN_W-1:0]         found_index_o,
  output logic [LEN_W-1:0]         list_length_o,
  output logic                     last_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Compare width: covers count, position and count+1 without wrap.
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Sequencer and control state.
  sle_state_e        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              hit_q, hit_d;
  logic              match_rule_q;

  // Latched command item.
  sle_mode_e         mode_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] key_q;

  // Search operands.
  logic [DATA_W-1:0] target_q, target_d;
  logic [DATA_W-1:0] prev_q, prev_d;

  // Staged single result.
  sle_status_e       res_status_q, res_status_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic [LEN_W-1:0]  res_fidx_q, res_fidx_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  sle_status_e       out_status_q, out_status_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic [LEN_W-1:0]  out_fidx_q, out_fidx_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic              out_last_q, out_last_d;

  // Element memory: one write and one registered read per cycle.
  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic              re, we;
  logic [AW-1:0]     ra, wa;
  logic [DATA_W-1:0] wd;
  logic [DATA_W-1:0] rdata_q;
  logic [AW-1:0]     rtag_q;
  logic              rvld_q;

  // Shared conditions.
  logic              accept, out_free;
  sle_mode_e         in_mode;
  logic [XW-1:0]     pos_in_x, pos_q_x, cnt_x, rtag_x, rtag_next_x, idx_x;
  logic              get_bad, ins_bad, is_full, append;
  logic              tag_at_pos, tag_is_end, rd_eq;
  logic              loc_hit, pred_hit, succ_hit, succ_arm;
  logic              search_hit, search_miss;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_mode     = sle_mode_e'(mode_i);

  assign pos_in_x    = XW'(position_i);
  assign pos_q_x     = XW'(pos_q);
  assign cnt_x       = XW'(count_q);
  assign rtag_x      = XW'(rtag_q);
  assign rtag_next_x = rtag_x + XW'(1);
  assign idx_x       = XW'(idx_q);

  assign get_bad     = (pos_in_x == '0) || (pos_in_x > cnt_x);
  assign ins_bad     = (pos_in_x == '0) || (pos_in_x > cnt_x + XW'(1));
  assign is_full     = (cnt_x == XW'(CAPACITY));
  assign append      = (pos_in_x == cnt_x + XW'(1));

  assign tag_at_pos  = (rtag_x == pos_q_x - XW'(1));
  assign tag_is_end  = (rtag_next_x == cnt_x);
  assign rd_eq       = (rdata_q == target_q);

  // Search outcomes, judged on the element that just came out of memory.
  assign loc_hit     = (mode_q == MODE_LOCATE) && rvld_q && rd_eq;
  assign pred_hit    = (mode_q == MODE_PRED) && rvld_q && (rtag_q != '0) && rd_eq;
  assign succ_hit    = (mode_q == MODE_SUCC) && hit_q;
  assign succ_arm    = (mode_q == MODE_SUCC) && rvld_q && !hit_q && rd_eq && !tag_is_end;
  assign search_hit  = loc_hit || pred_hit || succ_hit;
  assign search_miss = !search_hit && !succ_arm && rvld_q && tag_is_end;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_GET:    state_d = get_bad ? S_DONE : S_GET;
            MODE_INSERT: begin
              if (ins_bad || is_full) begin
                state_d = S_DONE;
              end else if (append) begin
                state_d = S_INS_KEY;
              end else begin
                state_d = S_INS_SHIFT;
              end
            end
            MODE_DELETE: state_d = get_bad ? S_DONE : S_DEL_WALK;
            MODE_LOCATE: begin
              if (count_q == '0) begin
                state_d = S_DONE;
              end else if (match_rule_q) begin
                state_d = S_SQUARE;
              end else begin
                state_d = S_SEARCH;
              end
            end
            MODE_PRED, MODE_SUCC: state_d = (count_q == '0) ? S_DONE : S_SEARCH;
            MODE_CLEAR:           state_d = S_DONE;
            MODE_READ_ALL:        state_d = (count_q == '0) ? S_DONE : S_READ_ALL;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_SQUARE:    state_d = S_SEARCH;
      S_GET:       state_d = S_DONE;
      S_INS_SHIFT: if (tag_at_pos) state_d = S_INS_KEY;
      S_INS_KEY:   state_d = S_DONE;
      S_DEL_WALK:  if (tag_is_end) state_d = S_DONE;
      S_SEARCH:    if (search_hit || search_miss) state_d = S_DONE;
      S_READ_ALL:  if (out_free && tag_is_end) state_d = S_IDLE;
      S_DONE:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath, memory port and output register control.
  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    hit_d        = hit_q;
    target_d     = target_q;
    prev_d       = prev_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_fidx_d   = res_fidx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_fidx_d   = out_fidx_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    re           = 1'b0;
    ra           = '0;
    we           = 1'b0;
    wa           = '0;
    wd           = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          hit_d        = 1'b0;
          idx_d        = '0;
          target_d     = key_value_i;
          res_status_d = ST_OK;
          res_data_d   = '0;
          res_fidx_d   = '0;
          case (in_mode)
            MODE_GET: begin
              if (get_bad) begin
                res_status_d = ST_BAD_POS;
              end else begin
                re = 1'b1;
                ra = AW'(pos_in_x - XW'(1));
              end
            end
            MODE_INSERT: begin
              if (ins_bad) begin
                res_status_d = ST_BAD_POS;
              end else if (is_full) begin
                res_status_d = ST_FULL;
              end else if (!append) begin
                // Start the upward shift at the last element.
                re = 1'b1;
                ra = AW'(cnt_x - XW'(1));
              end
            end
            MODE_DELETE: begin
              if (get_bad) begin
                res_status_d = ST_BAD_POS;
              end else begin
                re = 1'b1;
                ra = AW'(pos_in_x - XW'(1));
              end
            end
            MODE_LOCATE, MODE_PRED, MODE_SUCC: begin
              if (count_q == '0) res_status_d = ST_NONE;
            end
            MODE_CLEAR: count_d = '0;
            MODE_READ_ALL: begin
              if (count_q == '0) begin
                res_status_d = ST_NONE;
              end else begin
                re = 1'b1;
                ra = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_SQUARE: begin
        // Low word of the square is all the locate test needs.
        target_d = key_q * key_q;
      end

      S_GET: res_data_d = rdata_q;

      S_INS_SHIFT: begin
        // Move the element just read one place up; read the one below it.
        we = 1'b1;
        wa = AW'(rtag_next_x);
        wd = rdata_q;
        if (!tag_at_pos) begin
          re = 1'b1;
          ra = rtag_q - AW'(1);
        end
      end

      S_INS_KEY: begin
        we      = 1'b1;
        wa      = AW'(pos_q_x - XW'(1));
        wd      = key_q;
        count_d = count_q + CW'(1);
      end

      S_DEL_WALK: begin
        // First element read is the one removed; the rest move one place down.
        if (tag_at_pos) begin
          res_data_d = rdata_q;
        end else begin
          we = 1'b1;
          wa = rtag_q - AW'(1);
          wd = rdata_q;
        end
        if (tag_is_end) begin
          count_d = count_q - CW'(1);
        end else begin
          re = 1'b1;
          ra = AW'(rtag_next_x);
        end
      end

      S_SEARCH: begin
        if (idx_x < cnt_x) begin
          re    = 1'b1;
          ra    = AW'(idx_q);
          idx_d = idx_q + CW'(1);
        end
        if (rvld_q) prev_d = rdata_q;
        if (succ_arm) hit_d = 1'b1;
        if (search_hit) begin
          res_status_d = ST_OK;
          res_data_d   = pred_hit ? prev_q : rdata_q;
          res_fidx_d   = loc_hit ? LEN_W'(rtag_next_x) : '0;
        end else if (search_miss) begin
          res_status_d = ST_NONE;
          res_data_d   = '0;
          res_fidx_d   = '0;
        end
      end

      S_READ_ALL: begin
        // Hand each element straight to the output register; read the next
        // one only once this one has a place to go.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_data_d   = rdata_q;
          out_fidx_d   = '0;
          out_len_d    = LEN_W'(count_q);
          out_last_d   = tag_is_end;
          if (!tag_is_end) begin
            re = 1'b1;
            ra = AW'(rtag_next_x);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          out_fidx_d   = res_fidx_q;
          out_len_d    = LEN_W'(count_q);
          out_last_d   = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      match_rule_q <= 1'b0;
      out_valid_q  <= 1'b0;
      rvld_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      rvld_q      <= re;
      if (cfg_we_i) match_rule_q <= cfg_wdata_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_mode;
      pos_q  <= position_i;
      key_q  <= key_value_i;
    end
    target_q     <= target_d;
    prev_q       <= prev_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_fidx_q   <= res_fidx_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_fidx_q   <= out_fidx_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  // Element memory; read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (re) begin
      rdata_q <= mem_q[ra];
      rtag_q  <= ra;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign data_out_o    = out_data_q;
  assign found_index_o = out_fidx_q;
  assign list_length_o = out_len_q;
  assign last_o        = out_last_q;

  // Count never passes the store size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_x <= XW'(CAPACITY))
    else $error("list count exceeds capacity");

  // Every memory read targets a live element.
  assert property (@(posedge clk_i) disable iff (!rst_ni) re |-> (XW'(ra) < cnt_x))
    else $error("memory read beyond list length");

  // Shifts never read and write the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (re && we) |-> (ra != wa))
    else $error("read and write collide on one entry");

  // Insert commits exactly one new element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_KEY) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the list by one");

  // Count only moves on accept, insert commit or delete end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_INS_KEY && state_q != S_DEL_WALK)
      |=> $stable(count_q))
    else $error("list count changed outside a commit step");

endmodule

### test/testbench.sv
// Self-checking testbench for sequential_list_engine: a directed command table, then
// random command phases checked against a cycle-free list predictor kept in this file.
// Depends on rtl/sle_pkg.sv and rtl/sequential_list_engine.sv.
module testbench;
  import sle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP   = CAPACITY_DEF;
  localparam int TAIL_WAIT  = 3 * LIST_CAP;  // cycles allowed after the last result
  localparam int LONG_HOLD  = 300;           // receiver hold-off that backs up the input
  localparam int SCRIPT_LEN = 25;

  // One result item as the block should present it.
  typedef struct {
    sle_status_e status;
    logic [31:0] data;
    logic [6:0]  index;
    logic [6:0]  length;
    logic        last;
  } reply_t;

  // One row of the directed table; typed rows carry a hand-written result.
  typedef struct {
    sle_mode_e   mode;
    logic [6:0]  pos;
    logic [31:0] key;
    bit          typed;
    sle_status_e status;
    logic [31:0] data;
    logic [6:0]  length;
  } step_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         mode_i = '0;
  logic [POS_W-1:0]   position_i = '0;
  logic signed [31:0] key_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] data_out_o;
  logic [LEN_W-1:0]   found_index_o;
  logic [LEN_W-1:0]   list_length_o;
  logic               last_o;

  // Predictor state: the list contents, its length and the locate rule.
  logic [31:0] list_mem [LIST_CAP];
  int          list_len = 0;
  bit          square_rule = 1'b0;

  reply_t pending_replies [$];  // results still owed by the block, oldest first
  int     error_count = 0;
  bit     quiet_tail = 1'b0;    // set for the final stretch: no idling on either side
  bit     hold_req = 1'b0;      // asks the receiver for one long hold-off
  step_t  script [SCRIPT_LEN];

  sequential_list_engine uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .key_value_i  (key_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .found_index_o(found_index_o),
    .list_length_o(list_length_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Run one command through the list predictor and queue the results it owes.
  function automatic void apply_command(sle_mode_e mode, logic [6:0] pos, logic [31:0] key);
    reply_t      r;
    logic [31:0] target;
    int          p;
    int          i;
    p        = int'(pos);
    r.status = ST_OK;
    r.data   = '0;
    r.index  = '0;
    r.last   = 1'b1;
    case (mode)
      MODE_GET: begin
        if (p < 1 || p > list_len) r.status = ST_BAD_POS;
        else r.data = list_mem[p-1];
      end
      MODE_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          // open a slot at p, moving the tail up by one
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = key;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          r.data = list_mem[p-1];
          for (i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      MODE_LOCATE: begin
        // squared rule compares against the low 32 bits of key * key
        target   = square_rule ? key * key : key;
        r.status = ST_NONE;
        for (i = 0; i < list_len; i++) begin
          if (r.status == ST_NONE && list_mem[i] == target) begin
            r.status = ST_OK;
            r.data   = list_mem[i];
            r.index  = 7'(i + 1);
          end
        end
      end
      MODE_PRED: begin
        // the first element has no predecessor, so the scan starts at the second
        r.status = ST_NONE;
        for (i = 1; i < list_len; i++) begin
          if (r.status == ST_NONE && list_mem[i] == key) begin
            r.status = ST_OK;
            r.data   = list_mem[i-1];
          end
        end
      end
      MODE_SUCC: begin
        // the last element has no successor, so the scan stops one short
        r.status = ST_NONE;
        for (i = 0; i + 1 < list_len; i++) begin
          if (r.status == ST_NONE && list_mem[i] == key) begin
            r.status = ST_OK;
            r.data   = list_mem[i+1];
          end
        end
      end
      MODE_CLEAR: list_len = 0;
      default: begin
        if (list_len == 0) begin
          r.status = ST_NONE;
        end else begin
          // read-out: one result per element, last only on the final one
          r.length = 7'(list_len);
          for (i = 0; i < list_len; i++) begin
            r.data = list_mem[i];
            r.last = (i + 1 == list_len);
            pending_replies.push_back(r);
          end
          return;
        end
      end
    endcase
    r.length = 7'(list_len);
    pending_replies.push_back(r);
  endfunction

  // Mostly small keys (so squares and equal elements collide), else an element
  // already in the list, else anything at all.
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 32'($urandom_range(0, 12)) - 32'd3;
    if (r < 7 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
    return $urandom;
  endfunction

  // Mostly a position inside the list, sometimes any 7-bit value.
  function automatic logic [6:0] pick_pos(int top);
    if (top < 1 || $urandom_range(0, 99) < 15) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, top));
  endfunction

  // Offer one item, hold it until accepted, then book its expected results.
  task automatic offer_item(sle_mode_e mode, logic [6:0] pos, logic [31:0] key,
                            bit typed, reply_t typed_reply);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    position_i  <= pos;
    key_value_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    apply_command(mode, pos, key);
    if (typed) begin
      // hand-written rows replace what the predictor booked for them
      void'(pending_replies.pop_back());
      pending_replies.push_back(typed_reply);
    end
  endtask

  task automatic offer_random();
    sle_mode_e mode;
    reply_t    none;
    int        r;
    none = '{ST_OK, '0, '0, '0, 1'b0};
    r    = $urandom_range(0, 99);
    if (r < 30)      mode = MODE_INSERT;
    else if (r < 45) mode = MODE_DELETE;
    else if (r < 55) mode = MODE_GET;
    else if (r < 67) mode = MODE_LOCATE;
    else if (r < 75) mode = MODE_PRED;
    else if (r < 83) mode = MODE_SUCC;
    else if (r < 86) mode = MODE_CLEAR;
    else             mode = MODE_READ_ALL;
    offer_item(mode, pick_pos(mode == MODE_INSERT ? list_len + 1 : list_len), pick_key(),
               1'b0, none);
  endtask

  // Drop valid and wait until the block owes nothing and has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_match_rule(bit value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    square_rule = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: check every accepted result, then pick the next ready level.
  // Random stall bursts, plus one long hold-off on request.
  initial begin
    reply_t want;
    int     stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_replies.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: status %0d data %h length %0d last %0d",
                     status_o, data_out_o, list_length_o, last_o);
        end else begin
          want = pending_replies.pop_front();
          if (status_o !== want.status || data_out_o !== want.data ||
              found_index_o !== want.index || list_length_o !== want.length ||
              last_o !== want.last) begin
            error_count++;
            if (error_count <= 10)
              $display({"result mismatch: status %0d/%0d data %h/%h index %0d/%0d ",
                        "length %0d/%0d last %0d/%0d (got/expected)"},
                       status_o, want.status, data_out_o, want.data, found_index_o,
                       want.index, list_length_o, want.length, last_o, want.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Main sequence.
  initial begin
    reply_t typed_reply;
    reply_t none;
    none = '{ST_OK, '0, '0, '0, 1'b0};

    // Directed table. After the four inserts the list is
    // 0x80000000, 0xFFFFFFFF, 0x7FFFFFFF, 0x00000000.
    script = '{
      '{MODE_GET,      7'd1,   32'd0,          1'b1, ST_BAD_POS, 32'd0, 7'd0}, // empty get
      '{MODE_READ_ALL, 7'd0,   32'd0,          1'b1, ST_NONE,    32'd0, 7'd0}, // empty read-out
      '{MODE_DELETE,   7'd0,   32'd0,          1'b1, ST_BAD_POS, 32'd0, 7'd0},
      '{MODE_LOCATE,   7'd0,   32'd5,          1'b1, ST_NONE,    32'd0, 7'd0},
      '{MODE_PRED,     7'd0,   32'd5,          1'b1, ST_NONE,    32'd0, 7'd0},
      '{MODE_INSERT,   7'd2,   32'd7,          1'b1, ST_BAD_POS, 32'd0, 7'd0}, // past end+1
      '{MODE_INSERT,   7'd1,   32'h7FFF_FFFF,  1'b1, ST_OK,      32'd0, 7'd1},
      '{MODE_INSERT,   7'd1,   32'h8000_0000,  1'b1, ST_OK,      32'd0, 7'd2},
      '{MODE_INSERT,   7'd3,   32'd0,          1'b1, ST_OK,      32'd0, 7'd3}, // append
      '{MODE_INSERT,   7'd2,   32'hFFFF_FFFF,  1'b1, ST_OK,      32'd0, 7'd4},
      '{MODE_INSERT,   7'd6,   32'd1,          1'b1, ST_BAD_POS, 32'd0, 7'd4},
      '{MODE_INSERT,   7'd0,   32'd1,          1'b1, ST_BAD_POS, 32'd0, 7'd4},
      '{MODE_GET,      7'd127, 32'd0,          1'b1, ST_BAD_POS, 32'd0, 7'd4},
      '{MODE_GET,      7'd4,   32'd0,          1'b0, ST_OK,      32'd0, 7'd0},
      '{MODE_LOCATE,   7'd0,   32'hFFFF_FFFF,  1'b0, ST_OK,      32'd0, 7'd0},
      '{MODE_PRED,     7'd0,   32'h8000_0000,  1'b1, ST_NONE,    32'd0, 7'd4}, // head
      '{MODE_SUCC,     7'd0,   32'd0,          1'b1, ST_NONE,    32'd0, 7'd4}, // tail
      '{MODE_PRED,     7'd0,   32'd0,          1'b0, ST_OK,      32'd0, 7'd0},
      '{MODE_SUCC,     7'd0,   32'h8000_0000,  1'b0, ST_OK,      32'd0, 7'd0},
      '{MODE_READ_ALL, 7'd0,   32'd0,          1'b0, ST_OK,      32'd0, 7'd0},
      '{MODE_DELETE,   7'd5,   32'd0,          1'b1, ST_BAD_POS, 32'd0, 7'd4},
      '{MODE_DELETE,   7'd4,   32'd0,          1'b0, ST_OK,      32'd0, 7'd0},
      '{MODE_DELETE,   7'd1,   32'd0,          1'b0, ST_OK,      32'd0, 7'd0},
      '{MODE_CLEAR,    7'd0,   32'd0,          1'b1, ST_OK,      32'd0, 7'd0},
      '{MODE_READ_ALL, 7'd0,   32'd0,          1'b1, ST_NONE,    32'd0, 7'd0}
    };

    // Hold reset low from time zero, then release it on a rising edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Equality rule for the directed table.
    write_match_rule(1'b0);
    for (int n = 0; n < SCRIPT_LEN; n++) begin
      typed_reply = '{script[n].status, script[n].data, 7'd0, script[n].length, 1'b1};
      offer_item(script[n].mode, script[n].pos, script[n].key, script[n].typed, typed_reply);
    end

    // Squared locate rule with a random mix; small keys make square hits common.
    write_match_rule(1'b1);
    for (int n = 0; n < 45; n++) offer_random();

    // Fill the list to capacity while the receiver holds off, so the output
    // register backs up and the block stalls its input. Overfill to reach the
    // full status, then work on the full list.
    write_match_rule(1'b0);
    hold_req = 1'b1;
    offer_item(MODE_CLEAR, 7'd0, 32'd0, 1'b0, none);
    for (int n = 0; n < LIST_CAP + 2; n++)
      offer_item(MODE_INSERT, 7'($urandom_range(1, list_len + 1)), $urandom, 1'b0, none);
    offer_item(MODE_INSERT, 7'(LIST_CAP + 2), $urandom, 1'b0, none);
    offer_item(MODE_READ_ALL, 7'd0, 32'd0, 1'b0, none);
    offer_item(MODE_LOCATE, 7'd0, list_mem[LIST_CAP-1], 1'b0, none);
    offer_item(MODE_PRED, 7'd0, list_mem[LIST_CAP-1], 1'b0, none);
    offer_item(MODE_SUCC, 7'd0, list_mem[0], 1'b0, none);
    offer_item(MODE_GET, 7'(LIST_CAP), 32'd0, 1'b0, none);
    offer_item(MODE_GET, 7'(LIST_CAP + 1), 32'd0, 1'b0, none);
    offer_item(MODE_DELETE, 7'(LIST_CAP), 32'd0, 1'b0, none);
    offer_item(MODE_DELETE, 7'd1, 32'd0, 1'b0, none);

    // Equality rule again; the last stretch runs with no idling at all.
    write_match_rule(1'b0);
    for (int n = 0; n < 50; n++) begin
      if (n == 25) quiet_tail = 1'b1;
      offer_random();
    end

    // Wait for every owed result, then give the block time to show a stray one.
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
